>>> rtl/assert_macros.svh
// Assertion macros used by the port-level checker of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while rst is high.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/imuavg_pkg.sv
// Types and fixed constants of the six-axis inertial moving-average block.
package imuavg_pkg;

   // Field widths of the items
   localparam int FIELD_W   = 16;
   localparam int ACC_OUT_W = 16;
   localparam int DEG_OUT_W = 24;

   // Axis layout: three accelerations followed by three angular rates
   localparam int AXES     = 6;
   localparam int ACC_AXES = 3;

   // Radians to degrees, Q16 fraction: round(57.2958 * 65536)
   localparam int DEG_C_W = 22;
   localparam logic [DEG_C_W-1:0] DEG_PER_RAD_Q16 = 22'd3754938;
   localparam int DEG_FRAC_SHIFT = 16;

   typedef struct packed {
      logic signed [FIELD_W-1:0] accel_x;
      logic signed [FIELD_W-1:0] accel_y;
      logic signed [FIELD_W-1:0] accel_z;
      logic signed [FIELD_W-1:0] rate_x;
      logic signed [FIELD_W-1:0] rate_y;
      logic signed [FIELD_W-1:0] rate_z;
   } req_type;

   typedef struct packed {
      logic signed [ACC_OUT_W-1:0] mean_accel_x;
      logic signed [ACC_OUT_W-1:0] mean_accel_y;
      logic signed [ACC_OUT_W-1:0] mean_accel_z;
      logic signed [DEG_OUT_W-1:0] mean_deg_x;
      logic signed [DEG_OUT_W-1:0] mean_deg_y;
      logic signed [DEG_OUT_W-1:0] mean_deg_z;
   } rsp_type;

endpackage

>>> rtl/imu_six_axis_moving_average.sv
// Six-axis boxcar moving average over a sample ring RAM, gyro means in deg/s.
// An accepted item passes through the stage registers and the output register to rsp_valid.
// Throughput: one item per clock while rsp is not stalled; the ring RAM is read when an item is
// accepted and written back from stage 1 when the pipeline next advances, with a bypass when both touch the same slot.
// Reset clears sums, write slot and sensor_ready at once; ring slots carry valid
// bits cleared by reset, so an unwritten slot reads as zero and no clearing pass runs.
module imu_six_axis_moving_average #(
   parameter int WINDOW      = 10,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  imuavg_pkg::req_type  req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output imuavg_pkg::rsp_type  rsp_data,
   input  logic                 csr_we,
   input  logic                 csr_wdata
);

   localparam int AXES     = imuavg_pkg::AXES;
   localparam int ACC_AXES = imuavg_pkg::ACC_AXES;
   localparam int FIELD_W  = imuavg_pkg::FIELD_W;
   localparam int ACC_W    = imuavg_pkg::ACC_OUT_W;
   localparam int DEG_W    = imuavg_pkg::DEG_OUT_W;
   localparam int SB       = SAMPLE_BITS;
   localparam int RAW_W    = (SB > FIELD_W) ? SB : FIELD_W;
   localparam int SLOT_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CLOG_W   = $clog2(WINDOW);
   localparam int SUM_W    = SB + $clog2(WINDOW + 1);
   localparam int WORD_W   = AXES * SB;

   // Acceleration: q = floor((|sum| + W/2) / W) by ceiling reciprocal
   localparam logic [SUM_W-1:0] ROUND_ACC = SUM_W'(WINDOW / 2);
   localparam int KA    = SUM_W + CLOG_W;
   localparam int RA_W  = SUM_W + 1;
   localparam int AP_W  = SUM_W + RA_W;
   localparam logic [RA_W-1:0] RA =
      RA_W'(((64'd1 << KA) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));
   localparam int AQ_W  = SUM_W + 1 - CLOG_W;

   // Rate: q = floor(((|sum| * C + W * 2^15) >> 16) / W)
   localparam int DP_W  = SUM_W + imuavg_pkg::DEG_C_W;
   localparam logic [DP_W:0] ROUND_DEG =
      (DP_W + 1)'(64'(WINDOW) << (imuavg_pkg::DEG_FRAC_SHIFT - 1));
   localparam int T_W   = DP_W + 1 - imuavg_pkg::DEG_FRAC_SHIFT;
   localparam int KD    = T_W + CLOG_W;
   localparam int RD_W  = T_W + 1;
   localparam int RP_W  = T_W + RD_W;
   localparam logic [RD_W-1:0] RD =
      RD_W'(((64'd1 << KD) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));
   localparam int DQ_W  = T_W + 1 - CLOG_W;

   // Saturation limits on magnitudes
   localparam int CMP_A_W = (AQ_W > ACC_W) ? AQ_W : ACC_W;
   localparam int CMP_D_W = (DQ_W > DEG_W) ? DQ_W : DEG_W;
   localparam logic [CMP_A_W-1:0] ACC_CAP_POS = CMP_A_W'((64'd1 << (ACC_W - 1)) - 64'd1);
   localparam logic [CMP_A_W-1:0] ACC_CAP_NEG = CMP_A_W'(64'd1 << (ACC_W - 1));
   localparam logic [CMP_D_W-1:0] DEG_CAP_POS = CMP_D_W'((64'd1 << (DEG_W - 1)) - 64'd1);
   localparam logic [CMP_D_W-1:0] DEG_CAP_NEG = CMP_D_W'(64'd1 << (DEG_W - 1));

   // Handshake and configuration
   logic adv;
   logic accept;
   logic sensor_ready_ff;

   // Ring RAM and its read port
   logic [WORD_W-1:0] ring_mem [WINDOW];
   logic [WINDOW-1:0] ring_vld_ff;
   logic [WORD_W-1:0] rd_word_ff;
   logic              rd_vld_ff;
   logic [WORD_W-1:0] byp_word_ff;
   logic              byp_sel_ff;
   logic              byp_sel_in;
   logic [SLOT_W-1:0] slot_ff;
   logic [SLOT_W-1:0] slot_in;

   // Stage 1: read-modify-write of ring and sums
   logic                    s1_vld_ff;
   logic                    s1_go_ff;
   logic [SLOT_W-1:0]       s1_slot_ff;
   logic [WORD_W-1:0]       s1_word_ff;
   logic [WORD_W-1:0]       in_word;
   logic [FIELD_W-1:0]      in_field [AXES];
   logic [RAW_W-1:0]        in_raw   [AXES];
   logic [WORD_W-1:0]       old_word;
   logic                    s1_wr;
   logic signed [SUM_W-1:0] sum_ff [AXES];
   logic signed [SUM_W-1:0] sum_in [AXES];

   // Stage 2: sums of the item
   logic                    s2_vld_ff;
   logic signed [SUM_W-1:0] s2_sum_ff [AXES];
   logic signed [SUM_W-1:0] s2_sum_in [AXES];

   // Stage 3: sign and rounded magnitude
   logic              s3_vld_ff;
   logic [AXES-1:0]   s3_neg_ff;
   logic [AXES-1:0]   s3_neg_in;
   logic [SUM_W-1:0]  s3_mag_ff [AXES];
   logic [SUM_W-1:0]  s3_mag_in [AXES];
   logic [SUM_W-1:0]  s3_abs    [AXES];

   // Stage 4: first products
   logic              s4_vld_ff;
   logic [AXES-1:0]   s4_neg_ff;
   logic [AP_W-1:0]   s4_aprod_ff [ACC_AXES];
   logic [AP_W-1:0]   s4_aprod_in [ACC_AXES];
   logic [DP_W-1:0]   s4_dprod_ff [ACC_AXES];
   logic [DP_W-1:0]   s4_dprod_in [ACC_AXES];

   // Stage 5: accel quotient, rate sum scaled to Q0 (whole degrees)
   logic              s5_vld_ff;
   logic [AXES-1:0]   s5_neg_ff;
   logic [AQ_W-1:0]   s5_aq_ff [ACC_AXES];
   logic [AQ_W-1:0]   s5_aq_in [ACC_AXES];
   logic [T_W-1:0]    s5_t_ff  [ACC_AXES];
   logic [T_W-1:0]    s5_t_in  [ACC_AXES];
   logic [DP_W:0]     s5_dsum  [ACC_AXES];

   // Stage 6: rate reciprocal product
   logic              s6_vld_ff;
   logic [AXES-1:0]   s6_neg_ff;
   logic [AQ_W-1:0]   s6_aq_ff    [ACC_AXES];
   logic [RP_W-1:0]   s6_dprod_ff [ACC_AXES];
   logic [RP_W-1:0]   s6_dprod_in [ACC_AXES];

   // Output register
   logic                rsp_valid_ff;
   imuavg_pkg::rsp_type rsp_data_ff;
   imuavg_pkg::rsp_type rsp_data_in;
   logic [DQ_W-1:0]     out_dq    [ACC_AXES];
   logic [ACC_W-1:0]    out_alim  [ACC_AXES];
   logic [DEG_W-1:0]    out_dlim  [ACC_AXES];
   logic [ACC_W-1:0]    out_acc   [ACC_AXES];
   logic [DEG_W-1:0]    out_deg   [ACC_AXES];

   // Advance the whole pipeline whenever the output register can move on
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && adv;
   assign req_ready = adv;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Hold the sensor-ready register
   always_ff @(posedge clock) begin
      if (reset) begin
         sensor_ready_ff <= 1'b0;
      end else if (csr_we) begin
         sensor_ready_ff <= csr_wdata;
      end
   end

   // Pack the incoming item: low SAMPLE_BITS of each zero-extended field
   assign in_field[0] = req_data.accel_x;
   assign in_field[1] = req_data.accel_y;
   assign in_field[2] = req_data.accel_z;
   assign in_field[3] = req_data.rate_x;
   assign in_field[4] = req_data.rate_y;
   assign in_field[5] = req_data.rate_z;

   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         in_raw[a]              = RAW_W'(in_field[a]);
         in_word[a*SB +: SB]    = in_raw[a][SB-1:0];
      end
   end

   // Advance the write slot, wrapping at the window length
   assign slot_in = (slot_ff == SLOT_W'(WINDOW - 1)) ? '0 : slot_ff + SLOT_W'(1);

   // Bypass when the slot being read is written back at the same edge
   assign s1_wr      = adv && s1_vld_ff && s1_go_ff;
   assign byp_sel_in = accept && s1_vld_ff && s1_go_ff && (s1_slot_ff == slot_ff);

   // Ring RAM: write back from stage 1, registered read at acceptance
   always_ff @(posedge clock) begin
      if (s1_wr) begin
         ring_mem[s1_slot_ff] <= s1_word_ff;
      end
      if (adv) begin
         rd_word_ff <= ring_mem[slot_ff];
      end
   end

   // Slot valid bits, read pointer and bypass control
   always_ff @(posedge clock) begin
      if (reset) begin
         ring_vld_ff <= '0;
         slot_ff     <= '0;
         rd_vld_ff   <= 1'b0;
         byp_sel_ff  <= 1'b0;
      end else begin
         if (s1_wr) begin
            ring_vld_ff[s1_slot_ff] <= 1'b1;
         end
         if (accept && sensor_ready_ff) begin
            slot_ff <= slot_in;
         end
         if (adv) begin
            rd_vld_ff  <= ring_vld_ff[slot_ff];
            byp_sel_ff <= byp_sel_in;
         end
      end
   end

   // Stage 1 payload
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_slot_ff  <= slot_ff;
         s1_word_ff  <= in_word;
         byp_word_ff <= s1_word_ff;
      end
   end

   // Drop the oldest sample from each sum and add the new one
   always_comb begin
      if (byp_sel_ff) begin
         old_word = byp_word_ff;
      end else if (rd_vld_ff) begin
         old_word = rd_word_ff;
      end else begin
         old_word = '0;
      end
      for (int a = 0; a < AXES; a++) begin
         sum_in[a]    = sum_ff[a]
                      - SUM_W'($signed(old_word[a*SB +: SB]))
                      + SUM_W'($signed(s1_word_ff[a*SB +: SB]));
         s2_sum_in[a] = s1_go_ff ? sum_in[a] : '0;
      end
   end

   // Running sums
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < AXES; a++) begin
            sum_ff[a] <= '0;
         end
      end else if (s1_wr) begin
         for (int a = 0; a < AXES; a++) begin
            sum_ff[a] <= sum_in[a];
         end
      end
   end

   // Split sign and magnitude; add the half-window rounding term for accel
   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         s3_neg_in[a] = s2_sum_ff[a][SUM_W-1];
         s3_abs[a]    = s3_neg_in[a] ? SUM_W'(-s2_sum_ff[a]) : SUM_W'(s2_sum_ff[a]);
         s3_mag_in[a] = (a < ACC_AXES) ? s3_abs[a] + ROUND_ACC : s3_abs[a];
      end
   end

   // Multiply: accel by reciprocal of the window, rate by the degree factor
   always_comb begin
      for (int i = 0; i < ACC_AXES; i++) begin
         s4_aprod_in[i] = AP_W'(s3_mag_ff[i]) * AP_W'(RA);
         s4_dprod_in[i] = DP_W'(s3_mag_ff[ACC_AXES + i])
                        * DP_W'(imuavg_pkg::DEG_PER_RAD_Q16);
      end
   end

   // Take the accel quotient; round the rate product and drop the Q16 fraction
   always_comb begin
      for (int i = 0; i < ACC_AXES; i++) begin
         s5_aq_in[i] = s4_aprod_ff[i][AP_W-1:KA];
         s5_dsum[i]  = {1'b0, s4_dprod_ff[i]} + ROUND_DEG;
         s5_t_in[i]  = s5_dsum[i][DP_W:imuavg_pkg::DEG_FRAC_SHIFT];
         s6_dprod_in[i] = RP_W'(s5_t_ff[i]) * RP_W'(RD);
      end
   end

   // Saturate, restore sign and pack the result item
   always_comb begin
      for (int i = 0; i < ACC_AXES; i++) begin
         out_dq[i] = s6_dprod_ff[i][RP_W-1:KD];
         if (s6_neg_ff[i]) begin
            out_alim[i] = (CMP_A_W'(s6_aq_ff[i]) > ACC_CAP_NEG) ?
                          ACC_W'(ACC_CAP_NEG) : ACC_W'(s6_aq_ff[i]);
         end else begin
            out_alim[i] = (CMP_A_W'(s6_aq_ff[i]) > ACC_CAP_POS) ?
                          ACC_W'(ACC_CAP_POS) : ACC_W'(s6_aq_ff[i]);
         end
         if (s6_neg_ff[ACC_AXES + i]) begin
            out_dlim[i] = (CMP_D_W'(out_dq[i]) > DEG_CAP_NEG) ?
                          DEG_W'(DEG_CAP_NEG) : DEG_W'(out_dq[i]);
         end else begin
            out_dlim[i] = (CMP_D_W'(out_dq[i]) > DEG_CAP_POS) ?
                          DEG_W'(DEG_CAP_POS) : DEG_W'(out_dq[i]);
         end
         out_acc[i] = s6_neg_ff[i] ? -out_alim[i] : out_alim[i];
         out_deg[i] = s6_neg_ff[ACC_AXES + i] ? -out_dlim[i] : out_dlim[i];
      end
      rsp_data_in.mean_accel_x = out_acc[0];
      rsp_data_in.mean_accel_y = out_acc[1];
      rsp_data_in.mean_accel_z = out_acc[2];
      rsp_data_in.mean_deg_x   = out_deg[0];
      rsp_data_in.mean_deg_y   = out_deg[1];
      rsp_data_in.mean_deg_z   = out_deg[2];
   end

   // Pipeline valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff    <= 1'b0;
         s1_go_ff     <= 1'b0;
         s2_vld_ff    <= 1'b0;
         s3_vld_ff    <= 1'b0;
         s4_vld_ff    <= 1'b0;
         s5_vld_ff    <= 1'b0;
         s6_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff    <= accept;
         s1_go_ff     <= accept && sensor_ready_ff;
         s2_vld_ff    <= s1_vld_ff;
         s3_vld_ff    <= s2_vld_ff;
         s4_vld_ff    <= s3_vld_ff;
         s5_vld_ff    <= s4_vld_ff;
         s6_vld_ff    <= s5_vld_ff;
         rsp_valid_ff <= s6_vld_ff;
      end
   end

   // Pipeline payload; hold everything while the output is stalled
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int a = 0; a < AXES; a++) begin
            s2_sum_ff[a] <= s2_sum_in[a];
            s3_mag_ff[a] <= s3_mag_in[a];
         end
         s3_neg_ff <= s3_neg_in;
         s4_neg_ff <= s3_neg_ff;
         s5_neg_ff <= s4_neg_ff;
         s6_neg_ff <= s5_neg_ff;
         for (int i = 0; i < ACC_AXES; i++) begin
            s4_aprod_ff[i] <= s4_aprod_in[i];
            s4_dprod_ff[i] <= s4_dprod_in[i];
            s5_aq_ff[i]    <= s5_aq_in[i];
            s5_t_ff[i]     <= s5_t_in[i];
            s6_aq_ff[i]    <= s5_aq_ff[i];
            s6_dprod_ff[i] <= s6_dprod_in[i];
         end
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

>>> rtl/imuavg_checker.sv
// Port-level checker for the inertial moving-average block, bound to the top level.
`include "assert_macros.svh"

module imuavg_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input imuavg_pkg::rsp_type rsp_data
);

   // The input side is never blocked while the output register can move on
   `ASSERT_IMPLIES(a_ready_when_free, clock, reset, !rsp_valid || rsp_ready, req_ready, "req_ready low with output free")

   // The input side is blocked while a result waits
   `ASSERT_IMPLIES(a_block_when_full, clock, reset, rsp_valid && !rsp_ready, !req_ready, "req_ready high while result stalled")

   // A stalled result item stays offered and unchanged
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "stalled result item changed")

   // Reset leaves no result on offer
   `ASSERT_NEXT(a_rsp_reset, clock, 1'b0, reset, !rsp_valid, "result offered after reset")

endmodule

bind imu_six_axis_moving_average imuavg_checker u_imuavg_checker (.*);

>>> test/imu_mean_checker.sv
// Checker for the six-axis moving average: predicts each mean item and compares it.
module imu_mean_checker #(
   parameter int WINDOW = 10
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  imuavg_pkg::req_type req_data,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  imuavg_pkg::rsp_type rsp_data,
   input  logic                csr_we,
   input  logic                csr_wdata,
   output int                  mismatches,
   output int                  results_owed
);
   import imuavg_pkg::*;

   // Predicted filter state: sample history, exact running totals, write position
   logic signed [FIELD_W-1:0] sample_hist [WINDOW][AXES];
   longint                    axis_total [AXES];
   int                        write_pos;
   logic                      filter_on;

   // Means predicted for accepted items, oldest first
   rsp_type                   mean_q [$];
   rsp_type                   owed_mean;
   int                        slot_i, axis_i;

   // Divide, rounding to nearest with ties away from zero
   function automatic longint round_half_away(longint num, longint den);
      longint mag;
      mag = (num < 0) ? -num : num;
      mag = (mag + den / 2) / den;
      return (num < 0) ? -mag : mag;
   endfunction

   // Saturate to a signed field of the given width
   function automatic longint clamp_to(longint v, int bits);
      longint top_val, bot_val;
      top_val = (longint'(1) << (bits - 1)) - 1;
      bot_val = -top_val - 1;
      if (v > top_val)
         return top_val;
      if (v < bot_val)
         return bot_val;
      return v;
   endfunction

   // Advance the predicted filter by one sample and return the expected means
   function automatic rsp_type filter_step(req_type sample);
      longint  fresh [AXES];
      longint  deg_den;
      longint  deg_num;
      rsp_type means;
      int      a;
      means = '0;
      if (!filter_on)
         return means;
      fresh[0] = longint'(sample.accel_x);
      fresh[1] = longint'(sample.accel_y);
      fresh[2] = longint'(sample.accel_z);
      fresh[3] = longint'(sample.rate_x);
      fresh[4] = longint'(sample.rate_y);
      fresh[5] = longint'(sample.rate_z);
      // drop the oldest sample, store and add the new one
      for (a = 0; a < AXES; a++) begin
         axis_total[a] = axis_total[a] - sample_hist[write_pos][a] + fresh[a];
         sample_hist[write_pos][a] = fresh[a][FIELD_W-1:0];
      end
      write_pos = (write_pos == WINDOW - 1) ? 0 : write_pos + 1;
      means.mean_accel_x = ACC_OUT_W'(clamp_to(round_half_away(axis_total[0], WINDOW),
                                              ACC_OUT_W));
      means.mean_accel_y = ACC_OUT_W'(clamp_to(round_half_away(axis_total[1], WINDOW),
                                              ACC_OUT_W));
      means.mean_accel_z = ACC_OUT_W'(clamp_to(round_half_away(axis_total[2], WINDOW),
                                              ACC_OUT_W));
      // rates to deg/s in one rounding from the exact total
      deg_den = longint'(WINDOW) << DEG_FRAC_SHIFT;
      deg_num = axis_total[3] * longint'(DEG_PER_RAD_Q16);
      means.mean_deg_x = DEG_OUT_W'(clamp_to(round_half_away(deg_num, deg_den), DEG_OUT_W));
      deg_num = axis_total[4] * longint'(DEG_PER_RAD_Q16);
      means.mean_deg_y = DEG_OUT_W'(clamp_to(round_half_away(deg_num, deg_den), DEG_OUT_W));
      deg_num = axis_total[5] * longint'(DEG_PER_RAD_Q16);
      means.mean_deg_z = DEG_OUT_W'(clamp_to(round_half_away(deg_num, deg_den), DEG_OUT_W));
      return means;
   endfunction

   task automatic report_mismatch(string what);
      $display("%0t: mismatch: %s", $time, what);
      mismatches++;
   endtask

   task automatic compare_field(string name, logic [DEG_OUT_W-1:0] got,
                                logic [DEG_OUT_W-1:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0d, expected %0d", name, $signed(got),
                                   $signed(want)));
   endtask

   // Watch both channels and the register port at every edge
   always @(posedge clock) begin
      if (reset) begin
         for (slot_i = 0; slot_i < WINDOW; slot_i++)
            for (axis_i = 0; axis_i < AXES; axis_i++)
               sample_hist[slot_i][axis_i] = '0;
         for (axis_i = 0; axis_i < AXES; axis_i++)
            axis_total[axis_i] = 0;
         write_pos = 0;
         filter_on = 1'b0;
         mean_q.delete();
      end else begin
         // retire the oldest expectation against each accepted result
         if (rsp_valid && rsp_ready) begin
            if (mean_q.size() == 0) begin
               report_mismatch("result item with no input item outstanding");
            end else begin
               owed_mean = mean_q.pop_front();
               compare_field("mean_accel_x", DEG_OUT_W'(rsp_data.mean_accel_x),
                             DEG_OUT_W'(owed_mean.mean_accel_x));
               compare_field("mean_accel_y", DEG_OUT_W'(rsp_data.mean_accel_y),
                             DEG_OUT_W'(owed_mean.mean_accel_y));
               compare_field("mean_accel_z", DEG_OUT_W'(rsp_data.mean_accel_z),
                             DEG_OUT_W'(owed_mean.mean_accel_z));
               compare_field("mean_deg_x", rsp_data.mean_deg_x, owed_mean.mean_deg_x);
               compare_field("mean_deg_y", rsp_data.mean_deg_y, owed_mean.mean_deg_y);
               compare_field("mean_deg_z", rsp_data.mean_deg_z, owed_mean.mean_deg_z);
            end
         end
         if (req_valid && req_ready)
            mean_q.push_back(filter_step(req_data));
         if (csr_we)
            filter_on = csr_wdata;
      end
      results_owed <= mean_q.size();
   end

endmodule

>>> test/imu_six_axis_moving_average_test.sv
// Top of the moving-average testbench: clock, reset, sample stimulus and verdict.
module imu_six_axis_moving_average_test;
   import imuavg_pkg::*;

   localparam int     AVG_WINDOW   = 10;
   localparam int     PHASES       = 8;
   localparam int     PHASE_ITEMS  = 190;
   localparam int     DRAIN_CYCLES = 20;
   localparam longint RUN_LIMIT    = 10_000_000;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   req_type     req_data  = '0;
   logic        rsp_ready = 1'b0;
   logic        csr_we    = 1'b0;
   logic        csr_wdata = 1'b0;
   logic        req_ready;
   logic        rsp_valid;
   rsp_type     rsp_data;
   int          mismatches;
   int          results_owed;
   int          burst_left    = 0;
   logic [15:0] ready_pattern = 16'hffff;
   int          pattern_life  = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   imu_six_axis_moving_average #(
      .WINDOW      (AVG_WINDOW),
      .SAMPLE_BITS (FIELD_W)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   imu_mean_checker #(
      .WINDOW (AVG_WINDOW)
   ) mean_check (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata),
      .mismatches   (mismatches),
      .results_owed (results_owed)
   );

   // Stall the result channel on a rotating pattern, reloaded now and then
   always @(posedge clock) begin
      if (pattern_life == 0) begin
         pattern_life <= $urandom_range(16, 96);
         case ($urandom_range(0, 3))
            0: begin
               ready_pattern <= 16'hffff;
            end
            1: begin
               ready_pattern <= 16'($urandom) | 16'h0001;
            end
            2: begin
               ready_pattern <= 16'($urandom & $urandom) | 16'h0001;
            end
            default: begin
               ready_pattern <= 16'($urandom | $urandom) | 16'h0001;
            end
         endcase
      end else begin
         pattern_life  <= pattern_life - 1;
         ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
      end
      rsp_ready <= ready_pattern[0];
   end

   function automatic req_type make_sample(logic [15:0] ax, logic [15:0] ay,
                                           logic [15:0] az, logic [15:0] rx,
                                           logic [15:0] ry, logic [15:0] rz);
      req_type s;
      s.accel_x = ax;
      s.accel_y = ay;
      s.accel_z = az;
      s.rate_x  = rx;
      s.rate_y  = ry;
      s.rate_z  = rz;
      return s;
   endfunction

   // Mix of full-scale, near-zero and uniform values; loud leans on full scale
   function automatic logic [15:0] pick_field(bit loud);
      if (loud && $urandom_range(0, 1))
         return $urandom_range(0, 1) ? 16'h7fff - 16'($urandom_range(0, 40))
                                     : 16'h8000 + 16'($urandom_range(0, 40));
      case ($urandom_range(0, 5))
         0: return 16'h7fff;
         1: return 16'h8000;
         2: return 16'(int'($urandom_range(0, 15)) - 8);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic req_type random_sample(bit loud);
      return make_sample(pick_field(loud), pick_field(loud), pick_field(loud),
                         pick_field(loud), pick_field(loud), pick_field(loud));
   endfunction

   // Offer one sample, in bursts with random gaps between them
   task automatic send_sample(input req_type sample);
      int gap;
      if (burst_left == 0) begin
         gap        = $urandom_range(0, 12);
         burst_left = $urandom_range(1, 40);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data  <= sample;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      burst_left--;
   endtask

   // Drop valid and hold until every outstanding mean has come back
   task automatic settle();
      req_valid  <= 1'b0;
      burst_left = 0;
      do
         @(posedge clock);
      while (results_owed != 0);
   endtask

   task automatic write_ready_flag(input logic on);
      settle();
      csr_we    <= 1'b1;
      csr_wdata <= on;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   initial begin
      req_type hi_lo;
      req_type lo_hi;
      int      p;
      hi_lo = make_sample(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
      lo_hi = make_sample(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // sensor not ready out of reset: means forced to zero, state held
      send_sample(hi_lo);
      send_sample(lo_hi);
      write_ready_flag(1'b1);

      // warm-up with zeros in the window: half-way ties round away from zero
      send_sample(make_sample(16'd5, 16'd5, 16'd5, 16'd5, 16'd5, 16'd5));
      send_sample(make_sample(-16'sd10, -16'sd10, -16'sd10, -16'sd10, -16'sd10, -16'sd10));

      // fill the window at full scale both ways, wrapping the write position
      repeat (AVG_WINDOW) send_sample(hi_lo);
      repeat (AVG_WINDOW) send_sample(lo_hi);

      // random phases with the sensor flag rewritten between them
      for (p = 0; p < PHASES; p++) begin
         write_ready_flag(p % 4 != 3);
         repeat (PHASE_ITEMS) send_sample(random_sample(p % 2 == 1));
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // Abandon a hung run
   initial begin
      #(RUN_LIMIT);
      $display("Verification failed");
      $finish;
   end

endmodule

>>> imu_six_axis_moving_average.f
+incdir+rtl
rtl/imuavg_pkg.sv
rtl/imu_six_axis_moving_average.sv
rtl/imuavg_checker.sv
test/imu_mean_checker.sv
test/imu_six_axis_moving_average_test.sv
